[rtl/baro_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

    localparam int ADC_W      = 20;
    localparam int TEMP_W     = 16;
    localparam int PRESS_W    = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 2;

    // pipeline geometry
    localparam int FRONT_STAGES = 12;
    localparam int DIV_BITS     = 64;
    localparam int DIV_RADIX    = 2;
    localparam int DIV_STAGES   = DIV_BITS / DIV_RADIX;
    localparam int BACK_STAGES  = 8;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [20:0] PRESS_OFFSET = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE  = 12'd3125;
    localparam logic signed [24:0] TFINE_OFFSET = 25'sd128000;
    localparam logic signed [26:0] TEMP_ROUND   = 27'sd128;
    localparam logic [63:0] DIV_BIAS = 64'h0000_8000_0000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TEMP_COEFFS = 2'd0,
        REG_PRESS_LOW   = 2'd1,
        REG_PRESS_HIGH  = 2'd2,
        REG_PRESS_P9    = 2'd3
    } cfg_idx_t;

endpackage
`default_nettype wire

[rtl/barometric_sensor_compensation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature/pressure compensation, fully pipelined datapath.
// ----------------------------------------------------------------------------
// Pipeline: 12 front stages, 32 radix-4 divider stages and 8 back stages,
// then the output register that drives m_*.
// Throughput: one beat per cycle; the whole pipe advances while the output
// skid register is empty, so s_tready falls only when two results wait.
// Reset: aresetn synchronous active low clears valid bits (pipe, output,
// skid) and coefficient registers; datapath and output data are not reset.
module barometric_sensor_compensation (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [baro_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [baro_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [19:0] adc_temperature, [39:20] adc_pressure
    input  wire logic [baro_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [15:0] temperature_centi, [47:16] pressure_q24_8
    output logic [baro_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] divide_error
    output logic                                m_tuser
);

    localparam int NS = baro_pkg::PIPE_STAGES;
    localparam int DS = baro_pkg::DIV_STAGES;

    // ---------------- configuration ----------------
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_p9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_p9_reg    <= '0;
        end else if (cfg_we) begin
            case (baro_pkg::cfg_idx_t'(cfg_addr))
                baro_pkg::REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_wdata[47:0];
                baro_pkg::REG_PRESS_LOW:   press_low_reg   <= cfg_wdata;
                baro_pkg::REG_PRESS_HIGH:  press_high_reg  <= cfg_wdata;
                baro_pkg::REG_PRESS_P9:    press_p9_reg    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = $signed(temp_coeffs_reg[31:16]);
    assign t3 = $signed(temp_coeffs_reg[47:32]);
    assign p1 = press_low_reg[15:0];
    assign p2 = $signed(press_low_reg[31:16]);
    assign p3 = $signed(press_low_reg[47:32]);
    assign p4 = $signed(press_low_reg[63:48]);
    assign p5 = $signed(press_high_reg[15:0]);
    assign p6 = $signed(press_high_reg[31:16]);
    assign p7 = $signed(press_high_reg[47:32]);
    assign p8 = $signed(press_high_reg[63:48]);
    assign p9 = $signed(press_p9_reg);

    // ---------------- flow control ----------------
    logic          ce;
    logic [NS-1:0] v_reg;
    logic          skid_v_reg;
    logic          out_free;

    assign ce       = !skid_v_reg;
    assign s_tready = ce;
    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[NS-2:0], s_tvalid};
        end
    end

    // ---------------- S1: differences ----------------
    logic [19:0]        at_in, ap_in;
    logic signed [17:0] d1_reg;
    logic signed [16:0] d2_reg;
    logic [19:0]        ap_s1_reg;
    assign at_in = s_tdata[19:0];
    assign ap_in = s_tdata[39:20];

    always_ff @(posedge aclk) begin
        if (ce) begin
            d1_reg    <= $signed({1'b0, at_in[19:3]}) - $signed({1'b0, t1, 1'b0});
            d2_reg    <= $signed({1'b0, at_in[19:4]}) - $signed({1'b0, t1});
            ap_s1_reg <= ap_in;
        end
    end

    // ---------------- S2: first products ----------------
    logic signed [33:0] m1_reg, sq_full;
    logic [31:0]        sq_reg;
    logic [19:0]        ap_s2_reg;
    assign sq_full = 34'(d2_reg) * 34'(d2_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            m1_reg    <= 34'(d1_reg) * 34'(t2);
            sq_reg    <= sq_full[31:0];
            ap_s2_reg <= ap_s1_reg;
        end
    end

    // ---------------- S3 ----------------
    logic signed [22:0] u_reg;
    logic signed [36:0] m2_reg;
    logic [19:0]        ap_s3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            u_reg     <= m1_reg[33:11];
            m2_reg    <= 37'($signed({1'b0, sq_reg[31:12]})) * 37'(t3);
            ap_s3_reg <= ap_s2_reg;
        end
    end

    // ---------------- S4: t_fine ----------------
    logic signed [23:0] tfine_reg;
    logic [19:0]        ap_s4_reg;
    logic signed [22:0] w_val;
    assign w_val = m2_reg[36:14];

    always_ff @(posedge aclk) begin
        if (ce) begin
            tfine_reg <= 24'(u_reg) + 24'(w_val);
            ap_s4_reg <= ap_s3_reg;
        end
    end

    // ---------------- S5: temperature out, pressure offset ----------------
    logic signed [26:0] tf5;
    logic signed [18:0] ts_val;
    logic signed [15:0] ts_sat;
    logic signed [15:0] tc_s5_reg;
    logic signed [24:0] a0_reg;
    logic [19:0]        ap_s5_reg;

    always_comb begin
        tf5    = 27'(tfine_reg) + (27'(tfine_reg) <<< 2) + baro_pkg::TEMP_ROUND;
        ts_val = tf5[26:8];
        if (ts_val > 19'sd32767) begin
            ts_sat = 16'sd32767;
        end else if (ts_val < -19'sd32768) begin
            ts_sat = -16'sd32768;
        end else begin
            ts_sat = ts_val[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tc_s5_reg <= ts_sat;
            a0_reg    <= 25'(tfine_reg) - baro_pkg::TFINE_OFFSET;
            ap_s5_reg <= ap_s4_reg;
        end
    end

    // ---------------- S6 ----------------
    logic signed [49:0] aa_reg;
    logic signed [40:0] ap5_reg, ap2_reg;
    logic signed [15:0] tc_s6_reg;
    logic [19:0]        ap_s6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            aa_reg    <= 50'(a0_reg) * 50'(a0_reg);
            ap5_reg   <= 41'(a0_reg) * 41'(p5);
            ap2_reg   <= 41'(a0_reg) * 41'(p2);
            tc_s6_reg <= tc_s5_reg;
            ap_s6_reg <= ap_s5_reg;
        end
    end

    // ---------------- S7 ----------------
    logic signed [65:0] b1_full, a1_full;
    logic signed [63:0] b1_reg, a1_reg;
    logic signed [40:0] ap5_s7_reg, ap2_s7_reg;
    logic signed [15:0] tc_s7_reg;
    logic [19:0]        ap_s7_reg;
    assign b1_full = 66'(aa_reg) * 66'(p6);
    assign a1_full = 66'(aa_reg) * 66'(p3);

    always_ff @(posedge aclk) begin
        if (ce) begin
            b1_reg     <= b1_full[63:0];
            a1_reg     <= a1_full[63:0];
            ap5_s7_reg <= ap5_reg;
            ap2_s7_reg <= ap2_reg;
            tc_s7_reg  <= tc_s6_reg;
            ap_s7_reg  <= ap_s6_reg;
        end
    end

    // ---------------- S8 ----------------
    logic signed [63:0] b_reg, a2_reg;
    logic signed [15:0] tc_s8_reg;
    logic [19:0]        ap_s8_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_reg     <= b1_reg + (64'(ap5_s7_reg) <<< 17) + (64'(p4) <<< 35);
            a2_reg    <= (a1_reg >>> 8) + (64'(ap2_s7_reg) <<< 12);
            tc_s8_reg <= tc_s7_reg;
            ap_s8_reg <= ap_s7_reg;
        end
    end

    // ---------------- S9 ----------------
    logic [20:0]        pv;
    logic [63:0]        x_reg, y_reg;
    logic signed [15:0] tc_s9_reg;
    assign pv = baro_pkg::PRESS_OFFSET - {1'b0, ap_s8_reg};

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg     <= {11'd0, pv, 32'd0} >> 1;
            y_reg     <= baro_pkg::DIV_BIAS + $unsigned(a2_reg);
            tc_s9_reg <= tc_s8_reg;
        end
    end

    // the numerator subtract folds into S10 partials via x - b
    logic [63:0] b_s9_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            b_s9_reg <= $unsigned(b_reg);
        end
    end

    // ---------------- S10: x - b, then scale partials in S11 ----------------
    logic [63:0]        xn_reg, y_s10_reg;
    logic signed [15:0] tc_s10_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            xn_reg     <= x_reg - b_s9_reg;
            y_s10_reg  <= y_reg;
            tc_s10_reg <= tc_s9_reg;
        end
    end

    // ---------------- S11: 64 x small partial products ----------------
    logic [43:0]        xl_p, xh_p;
    logic [47:0]        yl_p, yh_p;
    logic [43:0]        xl_reg;
    logic [31:0]        xh_reg, yh_reg;
    logic [47:0]        yl_reg;
    logic signed [15:0] tc_s11_reg;
    assign xl_p = 44'(xn_reg[31:0]) * 44'(baro_pkg::PRESS_SCALE);
    assign xh_p = 44'(xn_reg[63:32]) * 44'(baro_pkg::PRESS_SCALE);
    assign yl_p = 48'(y_s10_reg[31:0]) * 48'(p1);
    assign yh_p = 48'(y_s10_reg[63:32]) * 48'(p1);

    always_ff @(posedge aclk) begin
        if (ce) begin
            xl_reg     <= xl_p;
            xh_reg     <= xh_p[31:0];
            yl_reg     <= yl_p;
            yh_reg     <= yh_p[31:0];
            tc_s11_reg <= tc_s10_reg;
        end
    end

    // ---------------- S12: operands, signs, magnitudes ----------------
    logic [63:0]        num_val, den_full;
    logic [30:0]        den_val;
    assign num_val  = 64'(xl_reg) + {xh_reg, 32'd0};
    assign den_full = 64'(yl_reg) + {yh_reg, 32'd0};
    assign den_val  = den_full[63:33];

    logic [30:0]        dv_rem_reg  [0:DS];
    logic [63:0]        dv_num_reg  [0:DS];
    logic [30:0]        dv_den_reg  [0:DS];
    logic               dv_neg_reg  [0:DS];
    logic               dv_err_reg  [0:DS];
    logic signed [15:0] dv_tc_reg   [0:DS];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_rem_reg[0] <= '0;
            dv_num_reg[0] <= num_val[63] ? (64'd0 - num_val) : num_val;
            dv_den_reg[0] <= den_val[30] ? (31'd0 - den_val) : den_val;
            dv_neg_reg[0] <= num_val[63] ^ den_val[30];
            dv_err_reg[0] <= (den_val == '0);
            dv_tc_reg[0]  <= tc_s11_reg;
        end
    end

    // ---------------- divider: restoring, two quotient bits per stage ------
    for (genvar g = 0; g < DS; g++) begin : g_div
        logic [30:0] rem_next;
        logic [63:0] num_next;

        always_comb begin
            logic [31:0] trial;
            logic [30:0] r;
            logic [63:0] n;
            r = dv_rem_reg[g];
            n = dv_num_reg[g];
            for (int s = 0; s < baro_pkg::DIV_RADIX; s++) begin
                trial = {r, n[63]};
                if (trial >= {1'b0, dv_den_reg[g]}) begin
                    trial = trial - {1'b0, dv_den_reg[g]};
                    n     = {n[62:0], 1'b1};
                end else begin
                    n     = {n[62:0], 1'b0};
                end
                r = trial[30:0];
            end
            rem_next = r;
            num_next = n;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_rem_reg[g+1] <= rem_next;
                dv_num_reg[g+1] <= num_next;
                dv_den_reg[g+1] <= dv_den_reg[g];
                dv_neg_reg[g+1] <= dv_neg_reg[g];
                dv_err_reg[g+1] <= dv_err_reg[g];
                dv_tc_reg[g+1]  <= dv_tc_reg[g];
            end
        end
    end

    // ---------------- Q: signed quotient ----------------
    logic [63:0]        q_reg;
    logic               err_q_reg;
    logic signed [15:0] tc_q_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            q_reg     <= dv_neg_reg[DS] ? (64'd0 - dv_num_reg[DS]) : dv_num_reg[DS];
            err_q_reg <= dv_err_reg[DS];
            tc_q_reg  <= dv_tc_reg[DS];
        end
    end

    // ---------------- P1: partials of s*s and q*p8 ----------------
    logic [63:0]        s_val;
    logic [31:0]        p8_ext, p9_ext;
    logic [63:0]        sx_full, eh_full;
    logic [63:0]        ssl_reg, q_p1_reg;
    logic [31:0]        ssx_reg, eh_reg;
    logic signed [48:0] el_reg;
    logic               err_p1_reg;
    logic signed [15:0] tc_p1_reg;
    assign s_val   = $unsigned($signed(q_reg) >>> 13);
    assign p8_ext  = $unsigned(32'(p8));
    assign p9_ext  = $unsigned(32'(p9));
    assign sx_full = 64'(s_val[63:32]) * 64'(s_val[31:0]);
    assign eh_full = 64'(q_reg[63:32]) * 64'(p8_ext);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ssl_reg    <= 64'(s_val[31:0]) * 64'(s_val[31:0]);
            ssx_reg    <= sx_full[31:0];
            el_reg     <= 49'($signed({1'b0, q_reg[31:0]})) * 49'(p8);
            eh_reg     <= eh_full[31:0];
            q_p1_reg   <= q_reg;
            err_p1_reg <= err_q_reg;
            tc_p1_reg  <= tc_q_reg;
        end
    end

    // ---------------- P2 ----------------
    logic [63:0]        ss_reg, ef_reg, q_p2_reg;
    logic               err_p2_reg;
    logic signed [15:0] tc_p2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ss_reg     <= ssl_reg + {ssx_reg[30:0], 1'b0, 32'd0};
            ef_reg     <= $unsigned(64'(el_reg)) + {eh_reg, 32'd0};
            q_p2_reg   <= q_p1_reg;
            err_p2_reg <= err_p1_reg;
            tc_p2_reg  <= tc_p1_reg;
        end
    end

    // ---------------- P3: e, partials of ss*p9 ----------------
    logic [63:0]        ch_full;
    logic [63:0]        e_reg, q_p3_reg;
    logic signed [48:0] cl_reg;
    logic [31:0]        ch_reg;
    logic               err_p3_reg;
    logic signed [15:0] tc_p3_reg;
    assign ch_full = 64'(ss_reg[63:32]) * 64'(p9_ext);

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_reg      <= $unsigned($signed(ef_reg) >>> 19);
            cl_reg     <= 49'($signed({1'b0, ss_reg[31:0]})) * 49'(p9);
            ch_reg     <= ch_full[31:0];
            q_p3_reg   <= q_p2_reg;
            err_p3_reg <= err_p2_reg;
            tc_p3_reg  <= tc_p2_reg;
        end
    end

    // ---------------- P4: c ----------------
    logic [63:0]        cf_val;
    logic [63:0]        c_reg, e_p4_reg, q_p4_reg;
    logic               err_p4_reg;
    logic signed [15:0] tc_p4_reg;
    assign cf_val = $unsigned(64'(cl_reg)) + {ch_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_reg      <= $unsigned($signed(cf_val) >>> 25);
            e_p4_reg   <= e_reg;
            q_p4_reg   <= q_p3_reg;
            err_p4_reg <= err_p3_reg;
            tc_p4_reg  <= tc_p3_reg;
        end
    end

    // ---------------- P5 ----------------
    logic [63:0]        t_reg;
    logic               err_p5_reg;
    logic signed [15:0] tc_p5_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg      <= q_p4_reg + c_reg + e_p4_reg;
            err_p5_reg <= err_p4_reg;
            tc_p5_reg  <= tc_p4_reg;
        end
    end

    // ---------------- P6 ----------------
    logic [63:0]        f_reg;
    logic               err_p6_reg;
    logic signed [15:0] tc_p6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_reg      <= $unsigned(($signed(t_reg) >>> 8) + (64'(p7) <<< 4));
            err_p6_reg <= err_p5_reg;
            tc_p6_reg  <= tc_p5_reg;
        end
    end

    // ---------------- P7: clamp, error select ----------------
    logic [31:0]        pres_val;
    logic [31:0]        pres_reg;
    logic               err_p7_reg;
    logic signed [15:0] tc_p7_reg;

    always_comb begin
        if (err_p6_reg || f_reg[63]) begin
            pres_val = '0;
        end else if (f_reg[62:32] != '0) begin
            pres_val = '1;
        end else begin
            pres_val = f_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pres_reg   <= pres_val;
            err_p7_reg <= err_p6_reg;
            tc_p7_reg  <= tc_p6_reg;
        end
    end

    // ---------------- output register + skid ----------------
    logic [baro_pkg::OUT_DATA_W-1:0] res_data;
    logic [baro_pkg::OUT_DATA_W-1:0] out_data_reg, skid_data_reg;
    logic                            out_err_reg, skid_err_reg, out_v_reg;
    assign res_data = {pres_reg, tc_p7_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (out_free) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end else if (v_reg[NS-1]) begin
            if (out_free) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (out_free) begin
                out_data_reg <= skid_data_reg;
                out_err_reg  <= skid_err_reg;
            end
        end else if (v_reg[NS-1]) begin
            if (out_free) begin
                out_data_reg <= res_data;
                out_err_reg  <= err_p7_reg;
            end else begin
                skid_data_reg <= res_data;
                skid_err_reg  <= err_p7_reg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule
`default_nettype wire

[rtl/baro_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// baro_checker
// Port-level checks for the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module baro_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [baro_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                            m_tuser
);

    // a flagged divide gives zero pressure
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[47:16] == '0)
        else $error("pressure not zero on divide error");

    // input only stalls when a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output empty");

    // held beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind barometric_sensor_compensation baro_checker u_baro_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
